/* hdl/rrv_pkg.sv */
// rrv_pkg: widths, constants, side-band payload type and the output clamp
// shared by the reflect/refract pipeline and its square-root unit.
// No dependencies.
`default_nettype none

package rrv_pkg;

  localparam int unsigned DW      = 16;  // Q2.14 vector component
  localparam int unsigned AW      = 3;   // APB address width
  localparam int unsigned ETA_W   = 16;
  localparam int unsigned RCP_W   = 13;
  localparam int unsigned RAD_W   = 56;  // radicand width (k >= 0)
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned SQ_BPS  = 2;   // root bits resolved per stage
  localparam int unsigned SQ_STG  = ROOT_W / SQ_BPS;

  localparam logic [ETA_W-1:0] ETA_RST = 16'd6144;
  localparam logic [RCP_W-1:0] RCP_RST = 13'd2731;

  // register indexes (paddr[2])
  localparam logic REG_ETA = 1'b0;
  localparam logic REG_RCP = 1'b1;

  localparam logic FUNC_REFLECT = 1'b0;

  // payload carried alongside the square root
  typedef struct packed {
    logic             func;
    logic             tir;
    logic [3:0][15:0] refl;   // finished reflect result
    logic [34:0]      etac;   // eta * c
    logic [3:0][32:0] etad;   // eta * d_i, signed
    logic [3:0][16:0] nn;     // chosen normal, signed
  } rrv_side_t;

  function automatic logic [DW-1:0] sat16(input logic signed [27:0] v);
    logic [DW-1:0] r;
    if (v > 28'sd32767) r = 16'h7fff;
    else if (v < -28'sd32768) r = 16'h8000;
    else r = v[DW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/reflect_refract_vector.sv */
// reflect_refract_vector: top level, mirror reflection or Snell refraction of
// a Q2.14 four-vector. Uses rrv_pkg and rrv_sqrt.
//
// Usage:
//  - Request: drive func_i, dir_*_i, nrm_*_i and pulse start. busy is always
//    low, so a request is taken on every cycle start is high.
//  - Result: done_o is high for one cycle with out_*_o and total_internal_o.
//    The receiver cannot stall; results come out in request order.
//  - Throughput: one request per cycle. The depth of the pipeline is set by
//    24 register stages: the 28-bit square root, 14 stages of two root bits
//    each, plus 10 arithmetic stages (dot product, multiplies, rounding and
//    clamping).
//  - Configuration: APB, register 0 (index_ratio, byte 0) and register 1
//    (index_ratio_recip, byte 4). Write only while no request is in flight.
//  - Reset: clears the pipeline valid bits and loads index_ratio = 1.5 and
//    index_ratio_recip = 2731 (about 1/1.5).
//  - Total internal reflection yields a zero vector with total_internal_o set.
`default_nettype none

module reflect_refract_vector import rrv_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [AW-1:0] paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          func_i,
  input  wire logic [15:0]   dir_x_i,
  input  wire logic [15:0]   dir_y_i,
  input  wire logic [15:0]   dir_z_i,
  input  wire logic [15:0]   dir_w_i,
  input  wire logic [15:0]   nrm_x_i,
  input  wire logic [15:0]   nrm_y_i,
  input  wire logic [15:0]   nrm_z_i,
  input  wire logic [15:0]   nrm_w_i,
  output logic               done_o,
  output logic [15:0]        out_x_o,
  output logic [15:0]        out_y_o,
  output logic [15:0]        out_z_o,
  output logic [15:0]        out_w_o,
  output logic               total_internal_o
);

  localparam logic signed [57:0] ONE_Q38 = 58'sd1 <<< 38;
  localparam logic signed [38:0] ONE_Q28 = 39'sd1 <<< 28;

  // ---------------- configuration ----------------
  logic [ETA_W-1:0] eta_q;
  logic [RCP_W-1:0] rcp_q;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = (paddr[2] == REG_RCP) ? {19'b0, rcp_q} : {16'b0, eta_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_q <= ETA_RST;
      rcp_q <= RCP_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_ETA) eta_q <= pwdata[ETA_W-1:0];
      else rcp_q <= pwdata[RCP_W-1:0];
    end
  end

  // ---------------- stage A: component products ----------------
  logic [3:0][15:0] din, nin;
  assign din = {dir_w_i, dir_z_i, dir_y_i, dir_x_i};
  assign nin = {nrm_w_i, nrm_z_i, nrm_y_i, nrm_x_i};

  logic                va_q, fa_q;
  logic signed [15:0]  da_q [4], na_q [4];
  logic signed [31:0]  pa_q [4];

  always_ff @(posedge clk_i) begin
    fa_q <= func_i;
    for (int i = 0; i < 4; i++) begin
      da_q[i] <= $signed(din[i]);
      na_q[i] <= $signed(nin[i]);
      pa_q[i] <= $signed(din[i]) * $signed(nin[i]);
    end
  end

  // ---------------- stage B: dot product ----------------
  logic                vb_q, fb_q;
  logic signed [15:0]  db_q [4], nb_q [4];
  logic signed [33:0]  dot_q;

  always_ff @(posedge clk_i) begin
    fb_q  <= fa_q;
    db_q  <= da_q;
    nb_q  <= na_q;
    dot_q <= 34'(pa_q[0]) + 34'(pa_q[1]) + 34'(pa_q[2]) + 34'(pa_q[3]);
  end

  // ---------------- stage C: side selection, cosine, D*n ----------------
  logic                entering;
  logic [33:0]         cf;
  logic [33:0]         cf_rnd;

  assign entering = dot_q[33];
  assign cf       = entering ? 34'(-dot_q) : dot_q;
  assign cf_rnd   = cf + 34'd8192;

  logic                vc_q, fc_q;
  logic signed [15:0]  dc_q [4];
  logic signed [16:0]  nnc_q [4];
  logic signed [49:0]  prc_q [4];
  logic [18:0]         cc_q;
  logic [ETA_W-1:0]    etac_sel_q;

  always_ff @(posedge clk_i) begin
    fc_q       <= fb_q;
    dc_q       <= db_q;
    cc_q       <= cf_rnd[32:14];
    etac_sel_q <= entering ? {3'b000, rcp_q} : eta_q;
    for (int i = 0; i < 4; i++) begin
      nnc_q[i] <= entering ? 17'(nb_q[i]) : -17'(nb_q[i]);
      prc_q[i] <= dot_q * nb_q[i];
    end
  end

  // ---------------- stage D: reflect result, c^2, eta products ----------------
  logic signed [51:0] accr [4];
  logic [3:0][15:0]   refl_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      accr[i]   = (52'(dc_q[i]) <<< 28) - (52'(prc_q[i]) <<< 1) + 52'sd134217728;
      refl_d[i] = sat16(28'($signed(accr[i][51:28])));
    end
  end

  logic        vd_q;
  rrv_side_t   sd_q;
  logic [37:0] csq_q;
  logic [31:0] eta2d_q;

  always_ff @(posedge clk_i) begin
    sd_q.func <= fc_q;
    sd_q.tir  <= 1'b0;
    sd_q.refl <= refl_d;
    sd_q.etac <= 35'(etac_sel_q) * 35'(cc_q);
    for (int i = 0; i < 4; i++) begin
      sd_q.etad[i] <= $signed({1'b0, etac_sel_q}) * dc_q[i];
      sd_q.nn[i]   <= nnc_q[i];
    end
    csq_q   <= 38'(cc_q) * 38'(cc_q);
    eta2d_q <= 32'(etac_sel_q) * 32'(etac_sel_q);
  end

  // ---------------- stage E: s rounded to Q.14 ----------------
  logic signed [38:0] s_full;
  assign s_full = ONE_Q28 - $signed({1'b0, csq_q}) + 39'sd8192;

  logic               ve_q;
  rrv_side_t          se_q;
  logic signed [24:0] s14_q;
  logic [31:0]        eta2e_q;

  always_ff @(posedge clk_i) begin
    se_q    <= sd_q;
    s14_q   <= s_full[38:14];
    eta2e_q <= eta2d_q;
  end

  // ---------------- stage F: eta^2 * s ----------------
  logic               vf_q;
  rrv_side_t          sf_q;
  logic signed [57:0] e2s_q;

  always_ff @(posedge clk_i) begin
    sf_q  <= se_q;
    e2s_q <= $signed({1'b0, eta2e_q}) * s14_q;
  end

  // ---------------- stage G: radicand and TIR test ----------------
  logic signed [57:0] kval;
  assign kval = ONE_Q38 - e2s_q;

  logic              vg_q;
  rrv_side_t         sg_d, sg_q;
  logic [RAD_W-1:0]  rad_q;

  always_comb begin
    sg_d     = sf_q;
    sg_d.tir = (sf_q.func != FUNC_REFLECT) && kval[57];
  end

  always_ff @(posedge clk_i) begin
    sg_q  <= sg_d;
    rad_q <= kval[RAD_W-1:0];
  end

  // ---------------- square root ----------------
  logic              vs;
  logic [ROOT_W-1:0] root;
  rrv_side_t         ss;

  rrv_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (vg_q),
    .in_rad_i   (rad_q),
    .in_side_i  (sg_q),
    .out_vld_o  (vs),
    .out_root_o (root),
    .out_side_o (ss)
  );

  // ---------------- stage H: m = eta*c - r*2^7 ----------------
  logic               vh_q;
  rrv_side_t          sh_q;
  logic signed [35:0] m_q;

  always_ff @(posedge clk_i) begin
    sh_q <= ss;
    m_q  <= $signed({1'b0, ss.etac}) - $signed({1'b0, root, 7'b0});
  end

  // ---------------- stage I: m * n' ----------------
  logic               vi_q;
  rrv_side_t          si_q;
  logic signed [52:0] mn_q [4];

  always_ff @(posedge clk_i) begin
    si_q <= sh_q;
    for (int i = 0; i < 4; i++) begin
      mn_q[i] <= m_q * $signed(sh_q.nn[i]);
    end
  end

  // ---------------- stage J: sum, round, clamp, select ----------------
  logic signed [53:0] accf [4];
  logic [3:0][15:0]   res_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      accf[i] = (54'($signed(si_q.etad[i])) <<< 14) + 54'(mn_q[i]) + 54'sd33554432;
      if (si_q.func == FUNC_REFLECT) res_d[i] = si_q.refl[i];
      else if (si_q.tir) res_d[i] = '0;
      else res_d[i] = sat16($signed(accf[i][53:26]));
    end
  end

  logic             vo_q, tir_q;
  logic [3:0][15:0] res_q;

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    tir_q <= si_q.tir;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      va_q <= start && !busy;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vs;
      vi_q <= vh_q;
      vo_q <= vi_q;
    end
  end

  assign done_o           = vo_q;
  assign out_x_o          = res_q[0];
  assign out_y_o          = res_q[1];
  assign out_z_o          = res_q[2];
  assign out_w_o          = res_q[3];
  assign total_internal_o = tir_q;

endmodule

`default_nettype wire

/* hdl/rrv_sqrt.sv */
// rrv_sqrt: pipelined digit-by-digit integer square root, SQ_BPS bits per
// stage, carrying an rrv_side_t payload with each request. Uses rrv_pkg.
`default_nettype none

module rrv_sqrt import rrv_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_vld_i,
  input  wire logic [RAD_W-1:0]  in_rad_i,
  input  wire rrv_side_t         in_side_i,
  output logic                   out_vld_o,
  output logic [ROOT_W-1:0]      out_root_o,
  output rrv_side_t              out_side_o
);

  logic              vld_q  [SQ_STG];
  logic [RAD_W-1:0]  rad_q  [SQ_STG];
  logic [REM_W-1:0]  rem_q  [SQ_STG];
  logic [ROOT_W-1:0] root_q [SQ_STG];
  rrv_side_t         side_q [SQ_STG];

  for (genvar g = 0; g < SQ_STG; g++) begin : g_stg
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in, rad_d;
    logic [REM_W-1:0]  rem_in, rem_d;
    logic [ROOT_W-1:0] root_in, root_d;
    rrv_side_t         side_in;

    if (g == 0) begin : g_first
      assign vld_in  = in_vld_i;
      assign rad_in  = in_rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      logic [REM_W+1:0] trial, test;
      rad_d  = rad_in;
      rem_d  = rem_in;
      root_d = root_in;
      trial  = '0;
      test   = '0;
      for (int b = 0; b < SQ_BPS; b++) begin
        trial = {rem_d, rad_d[RAD_W-1 -: 2]};
        test  = {2'b00, root_d, 2'b01};
        if (trial >= test) begin
          rem_d  = REM_W'(trial - test);
          root_d = {root_d[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = REM_W'(trial);
          root_d = {root_d[ROOT_W-2:0], 1'b0};
        end
        rad_d = rad_d << 2;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[g]  <= rad_d;
      rem_q[g]  <= rem_d;
      root_q[g] <= root_d;
      side_q[g] <= side_in;
    end
  end

  assign out_vld_o  = vld_q[SQ_STG-1];
  assign out_root_o = root_q[SQ_STG-1];
  assign out_side_o = side_q[SQ_STG-1];

endmodule

`default_nettype wire
